// ===== rtl/tws_pkg.sv =====
`timescale 1ns / 1ps

package tws_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_SETTLE_COUNT    = 2'd0;
    localparam logic [1:0] REG_JUMP_LIMIT      = 2'd1;
    localparam logic [1:0] REG_SWIPE_THRESHOLD = 2'd2;

    // Reset values of the configuration registers
    localparam logic [1:0] SETTLE_COUNT_RST    = 2'd3;
    localparam logic [3:0] JUMP_LIMIT_RST      = 4'd5;
    localparam logic [3:0] SWIPE_THRESHOLD_RST = 4'd8;

    // Wrap detection: near end and far end of the wheel
    localparam logic [3:0] NEAR_END_MAX = 4'd3;
    localparam logic [3:0] FAR_END_MIN  = 4'd12;
    localparam logic [3:0] WRAP_POS     = 4'd15;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    // Touch context held between scan ticks
    typedef struct packed {
        logic       released;
        logic [1:0] settle_counter;
        logic       held_valid;
        logic [3:0] held_position;
        logic [2:0] prior_zone;
        logic       tracking;
        logic [3:0] start_position;
        logic [3:0] end_position;
        logic [3:0] max_excursion;
        logic [3:0] previous_position;
    } ctx_t;

    // One result per scan tick
    typedef struct packed {
        logic       swipe_down;
        logic       swipe_valid;
        logic       all_dark;
        logic [2:0] old_zone;
        logic       zone_changed;
        logic [2:0] lit_zone;
        logic       sample_accepted;
    } res_t;

    // Runtime settings
    typedef struct packed {
        logic [1:0] settle_count;
        logic [3:0] jump_limit;
        logic [3:0] swipe_threshold;
    } cfg_t;

    function automatic logic [3:0] absdiff4(input logic [3:0] a, input logic [3:0] b);
        absdiff4 = (a > b) ? (a - b) : (b - a);
    endfunction

    // LED zone of a wheel position
    function automatic logic [2:0] zone_of(input logic [3:0] p);
        logic [2:0] z;
        z = 3'd7;
        if (p < 4'd1)        z = 3'd1;
        else if (p < 4'd4)   z = 3'd2;
        else if (p < 4'd8)   z = 3'd3;
        else if (p < 4'd11)  z = 3'd4;
        else if (p < 4'd14)  z = 3'd5;
        else if (p == 4'd14) z = 3'd6;
        zone_of = z;
    endfunction

    // Context after release or reset
    function automatic ctx_t ctx_idle();
        ctx_t c;
        c = '0;
        c.released = 1'b1;
        ctx_idle = c;
    endfunction

endpackage

// ===== rtl/tws_step.sv =====
`timescale 1ns / 1ps

module tws_step import tws_pkg::*; (
    input  cfg_t       cfg,
    input  ctx_t       ctx,
    input  logic       touch_detected,
    input  logic [3:0] wheel_pos,
    output ctx_t       ctx_next,
    output res_t       res
);

    logic       take;
    logic [2:0] zone;
    logic [3:0] excursion;

    assign zone      = zone_of(wheel_pos);
    assign excursion = absdiff4(ctx.start_position, wheel_pos);

    // Settle / jump filter
    always_comb begin
        take = 1'b0;
        if (touch_detected && ctx.settle_counter >= cfg.settle_count) begin
            if (!ctx.held_valid) begin
                take = 1'b1;
            end else if (absdiff4(ctx.held_position, wheel_pos) < cfg.jump_limit) begin
                take = 1'b1;
            end
        end
    end

    // Context update and result
    always_comb begin
        ctx_next = ctx;
        res      = '0;
        if (touch_detected) begin
            ctx_next.released = 1'b0;
            if (ctx.settle_counter < cfg.settle_count) begin
                ctx_next.settle_counter = ctx.settle_counter + 2'd1;
            end else if (!ctx.held_valid) begin
                ctx_next.held_valid = 1'b1;
            end
            if (take) begin
                res.sample_accepted    = 1'b1;
                ctx_next.held_position = wheel_pos;
                if (zone != ctx.prior_zone) begin
                    res.zone_changed    = 1'b1;
                    res.old_zone        = ctx.prior_zone;
                    ctx_next.prior_zone = zone;
                end
                if (!ctx.tracking) begin
                    ctx_next.tracking       = 1'b1;
                    ctx_next.start_position = wheel_pos;
                end else if (ctx.previous_position <= NEAR_END_MAX &&
                             wheel_pos >= FAR_END_MIN) begin
                    // near-to-far jump: treat as wrap
                    ctx_next.held_position  = WRAP_POS;
                    ctx_next.start_position = WRAP_POS;
                end else if (excursion > ctx.max_excursion) begin
                    ctx_next.end_position  = wheel_pos;
                    ctx_next.max_excursion = excursion;
                end
                ctx_next.previous_position = ctx_next.held_position;
            end
            res.lit_zone = ctx_next.prior_zone;
        end else if (!ctx.released) begin
            // release tick
            res.all_dark = 1'b1;
            if (ctx.max_excursion >= cfg.swipe_threshold) begin
                res.swipe_valid = 1'b1;
                res.swipe_down  = (ctx.start_position <= ctx.end_position);
            end
            ctx_next = ctx_idle();
        end
    end

endmodule

// ===== rtl/touch_wheel_swipe_detector_unit.sv =====
`timescale 1ns / 1ps

// Touch wheel swipe detector.
// s_ channel: one request per sensor scan tick (touch flag and wheel position).
// m_ channel: one result per request: accepted flag, LED zone lit/changed,
//   release (all dark) and swipe report with direction.
// cfg port: settle_count (0), jump_limit (1), swipe_threshold (2); write only
//   while no request is in flight.
// A request taken into the input register passes through the step logic into the
//   result register, which drives m_. Throughput: one request per cycle while
//   m_ is not stalled; the touch context is updated by the combinational step logic.
// Reset (aresetn low, synchronous): both channels empty, touch context
//   released and cleared, settings back to 3 / 5 / 8.
// When m_tready is low the result register holds; one more request is taken
//   into the input register, then s_tready drops until the result is taken.
module touch_wheel_swipe_detector_unit import tws_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // config write port
    input  logic                   cfg_wr_en,
    input  logic [1:0]             cfg_addr,
    input  logic [3:0]             cfg_wdata,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [0] touch_detected, [4:1] position, [7:5] zero
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] sample_accepted, [3:1] lit_zone, [4] zone_changed, [7:5] old_zone,
    // [8] all_dark, [9] swipe_valid, [10] swipe_down, [15:11] zero
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    cfg_t       cfg_reg;
    ctx_t       ctx_reg, ctx_next;
    res_t       res_next, res_reg;
    logic       in_valid_reg;
    logic       in_touch_reg;
    logic [3:0] in_pos_reg;
    logic       out_valid_reg;
    logic       fire;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    // settings
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.settle_count    <= SETTLE_COUNT_RST;
            cfg_reg.jump_limit      <= JUMP_LIMIT_RST;
            cfg_reg.swipe_threshold <= SWIPE_THRESHOLD_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_SETTLE_COUNT:    cfg_reg.settle_count    <= cfg_wdata[1:0];
                REG_JUMP_LIMIT:      cfg_reg.jump_limit      <= cfg_wdata;
                REG_SWIPE_THRESHOLD: cfg_reg.swipe_threshold <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_touch_reg <= s_tdata[0];
            in_pos_reg   <= s_tdata[4:1];
        end
    end

    tws_step u_step (
        .cfg            (cfg_reg),
        .ctx            (ctx_reg),
        .touch_detected (in_touch_reg),
        .wheel_pos      (in_pos_reg),
        .ctx_next       (ctx_next),
        .res            (res_next)
    );

    // touch context
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctx_reg <= ctx_idle();
        end else if (fire) begin
            ctx_reg <= ctx_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - $bits(res_t)){1'b0}}, res_reg};

endmodule

// ===== rtl/tws_checker.sv =====
`timescale 1ns / 1ps

module tws_checker import tws_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // release tick never accepts a sample
    a_dark_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8] |-> !m_tdata[0] && m_tdata[3:1] == 3'd0)
        else $error("release tick with sample or lit zone");

    // swipe only on release, direction only with swipe
    a_swipe_on_release: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[9] || m_tdata[10]) |-> m_tdata[8] && m_tdata[9])
        else $error("swipe outside release");

    // zone change only on an accepted sample, to a different lit zone
    a_zone_change: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |-> m_tdata[0] && m_tdata[3:1] != m_tdata[7:5]
                                   && m_tdata[3:1] != 3'd0)
        else $error("bad zone change");

endmodule

bind touch_wheel_swipe_detector_unit tws_checker u_tws_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
